/* src/aabb_pkg.sv */
// Package for the box transform and metrics core: widths, register indexes,
// axis codes, shared structs and the coordinate saturation helper.
// No dependencies.
package aabb_pkg;

  // Coordinate and coefficient formats
  localparam int COORD_W = 24;                   // signed Q15.8 coordinate
  localparam int COEF_W = 16;                    // signed Q3.12 coefficient
  localparam int FRAC_W = 12;                    // coefficient fraction bits
  localparam int ROW_W = 3 * COEF_W;             // one packed coefficient row
  localparam int PROD_W = COEF_W + COORD_W;      // coef * coord
  localparam int ACC_W = PROD_W + 2;             // sum of three products
  localparam int SH_W = ACC_W - FRAC_W;          // after dropping fraction
  localparam int SUM_W = ((SH_W > COORD_W) ? SH_W : COORD_W) + 1;

  // Area format
  localparam int AREA_W = 52;
  localparam int EXTP_W = 2 * COORD_W;           // extent product
  localparam int AREA_FULL_W = EXTP_W + 3;       // 2 * (sum of three)
  localparam int AREA_WIDE_W = (AREA_FULL_W > AREA_W) ? AREA_FULL_W : AREA_W;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ROW_W;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd5;

  // Identity reset rows: 1.0 on the diagonal
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);
  localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(COEF_ONE);
  localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(COEF_ONE) << COEF_W;
  localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(COEF_ONE) << (2 * COEF_W);

  // Longest axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Transform setup: coef[out_axis][in_axis], off[out_axis]
  typedef struct packed {
    logic [2:0][2:0][COEF_W-1:0] coef;
    logic [2:0][COORD_W-1:0]     off;
  } cfg_t;

  // Box word: lower and upper bound per axis, with its valid bit
  typedef struct packed {
    logic                    valid;
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
  } box_t;

  // Result word
  typedef struct packed {
    logic                    valid;
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
    logic [2:0][COORD_W-1:0] mid;
    logic [AREA_W-1:0]       area;
    logic [1:0]              axis;
  } res_t;

  // Clamp a wide signed value into the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){1'b0}}) ||
           (v[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){1'b1}});
    if (fits) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* src/aabb_transform_and_metrics_core.sv */
// Top level of the box transform and metrics core.
// Depends on aabb_pkg, aabb_cfg_regs, aabb_xform and aabb_metrics.
//
//  Channel  | Handshake              | Word
//  ---------+------------------------+-----------------------------------------
//  input    | start && !busy         | in_xmin .. in_zmax
//  result   | out_valid, one cycle   | out_xmin .. out_zmax, out_mid_*, area, axis
//  config   | cfg_we                 | cfg_index, cfg_wdata
//
// One word is taken every cycle; busy is always low.
// Three transform stages and three metrics stages; the
// 16x24 coefficient products and the 24x24 extent products set the stages.
// Synchronous active-low reset clears the valid bits and loads the identity.
// The receiver cannot stall, so the pipeline advances every cycle.
module aabb_transform_and_metrics_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_xmin,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_xmax,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_ymin,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_ymax,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_zmin,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_zmax,
  output logic                               out_valid,
  output logic signed [aabb_pkg::COORD_W-1:0] out_xmin,
  output logic signed [aabb_pkg::COORD_W-1:0] out_xmax,
  output logic signed [aabb_pkg::COORD_W-1:0] out_ymin,
  output logic signed [aabb_pkg::COORD_W-1:0] out_ymax,
  output logic signed [aabb_pkg::COORD_W-1:0] out_zmin,
  output logic signed [aabb_pkg::COORD_W-1:0] out_zmax,
  output logic signed [aabb_pkg::COORD_W-1:0] out_mid_x,
  output logic signed [aabb_pkg::COORD_W-1:0] out_mid_y,
  output logic signed [aabb_pkg::COORD_W-1:0] out_mid_z,
  output logic [aabb_pkg::AREA_W-1:0]         out_area,
  output logic [1:0]                          out_longest_axis,
  input  logic                               cfg_we,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aabb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  aabb_pkg::cfg_t cfg;
  aabb_pkg::box_t box_in;
  aabb_pkg::box_t box_xf;
  aabb_pkg::res_t res;

  // Fully pipelined: never refuses a word
  assign busy = 1'b0;

  // Input word
  assign box_in.valid = start && !busy;
  assign box_in.lo    = {in_zmin, in_ymin, in_xmin};
  assign box_in.hi    = {in_zmax, in_ymax, in_xmax};

  aabb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aabb_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .box_in  (box_in),
    .cfg     (cfg),
    .box_out (box_xf)
  );

  aabb_metrics u_metrics (
    .clk    (clk),
    .rst_n  (rst_n),
    .box_in (box_xf),
    .res    (res)
  );

  // Result word
  assign out_valid        = res.valid;
  assign out_xmin         = res.lo[0];
  assign out_ymin         = res.lo[1];
  assign out_zmin         = res.lo[2];
  assign out_xmax         = res.hi[0];
  assign out_ymax         = res.hi[1];
  assign out_zmax         = res.hi[2];
  assign out_mid_x        = res.mid[0];
  assign out_mid_y        = res.mid[1];
  assign out_mid_z        = res.mid[2];
  assign out_area         = res.area;
  assign out_longest_axis = res.axis;

endmodule

/* src/aabb_cfg_regs.sv */
// Configuration register file: three coefficient rows and three offsets.
// Depends on aabb_pkg.
module aabb_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aabb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output aabb_pkg::cfg_t                   cfg
);

  logic [2:0][aabb_pkg::ROW_W-1:0]   row_r;
  logic [2:0][aabb_pkg::COORD_W-1:0] off_r;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= aabb_pkg::ROW_X_RST;
      row_r[1] <= aabb_pkg::ROW_Y_RST;
      row_r[2] <= aabb_pkg::ROW_Z_RST;
      off_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aabb_pkg::REG_ROW_X: row_r[0] <= cfg_wdata;
        aabb_pkg::REG_ROW_Y: row_r[1] <= cfg_wdata;
        aabb_pkg::REG_ROW_Z: row_r[2] <= cfg_wdata;
        aabb_pkg::REG_OFF_X: off_r[0] <= cfg_wdata[aabb_pkg::COORD_W-1:0];
        aabb_pkg::REG_OFF_Y: off_r[1] <= cfg_wdata[aabb_pkg::COORD_W-1:0];
        aabb_pkg::REG_OFF_Z: off_r[2] <= cfg_wdata[aabb_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Row packing: bits 15:0 multiply x, 31:16 y, 47:32 z
  assign cfg.coef = row_r;
  assign cfg.off  = off_r;

endmodule

/* src/aabb_xform.sv */
// Three-stage bound transform: products, per-term min/max sums, then
// fraction drop, offset and saturation. Depends on aabb_pkg.
module aabb_xform (
  input  logic            clk,
  input  logic            rst_n,
  input  aabb_pkg::box_t  box_in,
  input  aabb_pkg::cfg_t  cfg,
  output aabb_pkg::box_t  box_out
);

  localparam int PW = aabb_pkg::PROD_W;
  localparam int AW = aabb_pkg::ACC_W;
  localparam int SW = aabb_pkg::SUM_W;

  // The transform is linear per term and the rest is monotone, so the
  // corner extremes come from picking the smaller/larger product per term.

  // Stage 1: nine coefficients times both bounds
  logic                 s1_valid_r;
  logic signed [PW-1:0] p_lo_r [3][3];
  logic signed [PW-1:0] p_hi_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= box_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        p_lo_r[a][j] <= $signed(cfg.coef[a][j]) * $signed(box_in.lo[j]);
        p_hi_r[a][j] <= $signed(cfg.coef[a][j]) * $signed(box_in.hi[j]);
      end
    end
  end

  // Stage 2: sum of smaller terms and sum of larger terms per output axis
  logic                 s2_valid_r;
  logic signed [AW-1:0] acc_lo_r [3];
  logic signed [AW-1:0] acc_hi_r [3];
  logic signed [AW-1:0] acc_lo_nxt [3];
  logic signed [AW-1:0] acc_hi_nxt [3];

  always_comb begin
    logic signed [PW-1:0] mn;
    logic signed [PW-1:0] mx;
    for (int a = 0; a < 3; a++) begin
      acc_lo_nxt[a] = '0;
      acc_hi_nxt[a] = '0;
      for (int j = 0; j < 3; j++) begin
        if (p_lo_r[a][j] < p_hi_r[a][j]) begin
          mn = p_lo_r[a][j];
          mx = p_hi_r[a][j];
        end else begin
          mn = p_hi_r[a][j];
          mx = p_lo_r[a][j];
        end
        acc_lo_nxt[a] = acc_lo_nxt[a] + AW'(mn);
        acc_hi_nxt[a] = acc_hi_nxt[a] + AW'(mx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      acc_lo_r[a] <= acc_lo_nxt[a];
      acc_hi_r[a] <= acc_hi_nxt[a];
    end
  end

  // Stage 3: floor shift, add offset, saturate
  logic                               s3_valid_r;
  logic [2:0][aabb_pkg::COORD_W-1:0]  lo_r;
  logic [2:0][aabb_pkg::COORD_W-1:0]  hi_r;
  logic [2:0][aabb_pkg::COORD_W-1:0]  lo_nxt;
  logic [2:0][aabb_pkg::COORD_W-1:0]  hi_nxt;

  always_comb begin
    logic signed [SW-1:0] t_lo;
    logic signed [SW-1:0] t_hi;
    logic signed [SW-1:0] off_w;
    for (int a = 0; a < 3; a++) begin
      off_w = SW'($signed(cfg.off[a]));
      t_lo  = SW'($signed(acc_lo_r[a][AW-1:aabb_pkg::FRAC_W])) + off_w;
      t_hi  = SW'($signed(acc_hi_r[a][AW-1:aabb_pkg::FRAC_W])) + off_w;
      lo_nxt[a] = aabb_pkg::sat_coord(t_lo);
      hi_nxt[a] = aabb_pkg::sat_coord(t_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign box_out.valid = s3_valid_r;
  assign box_out.lo    = lo_r;
  assign box_out.hi    = hi_r;

endmodule

/* src/aabb_metrics.sv */
// Three-stage box metrics: extents and midpoints, extent products and
// longest axis, then saturated surface area. Depends on aabb_pkg.
module aabb_metrics (
  input  logic            clk,
  input  logic            rst_n,
  input  aabb_pkg::box_t  box_in,
  output aabb_pkg::res_t  res
);

  localparam int CW = aabb_pkg::COORD_W;
  localparam int EW = aabb_pkg::EXTP_W;
  localparam int WW = aabb_pkg::AREA_WIDE_W;

  // Stage 4: extent = hi - lo, midpoint = floor((lo + hi) / 2)
  logic                 s4_valid_r;
  logic [2:0][CW-1:0]   s4_lo_r;
  logic [2:0][CW-1:0]   s4_hi_r;
  logic [2:0][CW-1:0]   s4_mid_r;
  logic [2:0][CW-1:0]   s4_ext_r;
  logic [2:0][CW-1:0]   mid_nxt;
  logic [2:0][CW-1:0]   ext_nxt;

  always_comb begin
    logic [CW:0] lo_x;
    logic [CW:0] hi_x;
    logic [CW:0] s;
    logic [CW:0] d;
    for (int a = 0; a < 3; a++) begin
      lo_x = {box_in.lo[a][CW-1], box_in.lo[a]};
      hi_x = {box_in.hi[a][CW-1], box_in.hi[a]};
      s = lo_x + hi_x;
      d = hi_x - lo_x;
      mid_nxt[a] = s[CW:1];
      ext_nxt[a] = d[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= box_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_lo_r  <= box_in.lo;
    s4_hi_r  <= box_in.hi;
    s4_mid_r <= mid_nxt;
    s4_ext_r <= ext_nxt;
  end

  // Stage 5: pairwise extent products and longest axis (ties go to the later axis: y over x, z over both)
  logic                 s5_valid_r;
  logic [2:0][CW-1:0]   s5_lo_r;
  logic [2:0][CW-1:0]   s5_hi_r;
  logic [2:0][CW-1:0]   s5_mid_r;
  logic [EW-1:0]        prod_r [3];
  logic [1:0]           s5_axis_r;
  logic [1:0]           axis_nxt;

  always_comb begin
    if (s4_ext_r[0] > s4_ext_r[1] && s4_ext_r[0] > s4_ext_r[2]) begin
      axis_nxt = aabb_pkg::AXIS_X;
    end else if (s4_ext_r[1] > s4_ext_r[2]) begin
      axis_nxt = aabb_pkg::AXIS_Y;
    end else begin
      axis_nxt = aabb_pkg::AXIS_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_lo_r   <= s4_lo_r;
    s5_hi_r   <= s4_hi_r;
    s5_mid_r  <= s4_mid_r;
    s5_axis_r <= axis_nxt;
    prod_r[0] <= s4_ext_r[0] * s4_ext_r[2];
    prod_r[1] <= s4_ext_r[1] * s4_ext_r[2];
    prod_r[2] <= s4_ext_r[1] * s4_ext_r[0];
  end

  // Stage 6: area = 2 * sum, clamped to the area field
  logic [WW-1:0]               tot;
  logic [aabb_pkg::AREA_W-1:0] area_nxt;
  logic                        s6_valid_r;
  logic [2:0][CW-1:0]          s6_lo_r;
  logic [2:0][CW-1:0]          s6_hi_r;
  logic [2:0][CW-1:0]          s6_mid_r;
  logic [aabb_pkg::AREA_W-1:0] s6_area_r;
  logic [1:0]                  s6_axis_r;

  always_comb begin
    tot = (WW'(prod_r[0]) + WW'(prod_r[1]) + WW'(prod_r[2])) << 1;
    if (tot > WW'(aabb_pkg::AREA_MAX)) begin
      area_nxt = aabb_pkg::AREA_MAX;
    end else begin
      area_nxt = tot[aabb_pkg::AREA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_lo_r   <= s5_lo_r;
    s6_hi_r   <= s5_hi_r;
    s6_mid_r  <= s5_mid_r;
    s6_area_r <= area_nxt;
    s6_axis_r <= s5_axis_r;
  end

  assign res.valid = s6_valid_r;
  assign res.lo    = s6_lo_r;
  assign res.hi    = s6_hi_r;
  assign res.mid   = s6_mid_r;
  assign res.area  = s6_area_r;
  assign res.axis  = s6_axis_r;

endmodule

/* src/aabb_chk.sv */
// Port-level checker for the box transform and metrics core, with its bind.
// Depends on aabb_pkg and aabb_transform_and_metrics_core.
module aabb_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [aabb_pkg::COORD_W-1:0] out_xmin,
  input logic signed [aabb_pkg::COORD_W-1:0] out_xmax,
  input logic signed [aabb_pkg::COORD_W-1:0] out_ymin,
  input logic signed [aabb_pkg::COORD_W-1:0] out_ymax,
  input logic signed [aabb_pkg::COORD_W-1:0] out_zmin,
  input logic signed [aabb_pkg::COORD_W-1:0] out_zmax,
  input logic signed [aabb_pkg::COORD_W-1:0] out_mid_x,
  input logic signed [aabb_pkg::COORD_W-1:0] out_mid_y,
  input logic signed [aabb_pkg::COORD_W-1:0] out_mid_z,
  input logic [1:0]                          out_longest_axis
);

  // Every accepted word comes out as a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted word did not come out after six cycles");

  // No result strobe without a matching accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result strobe without a matching accepted word");

  // Output bounds are ordered
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_xmin <= out_xmax) && (out_ymin <= out_ymax) &&
                  (out_zmin <= out_zmax))
    else $error("output bounds out of order");

  // Midpoint lies within its bounds and the axis code is a real axis
  a_mid_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_xmin <= out_mid_x) && (out_mid_x <= out_xmax) &&
                  (out_ymin <= out_mid_y) && (out_mid_y <= out_ymax) &&
                  (out_zmin <= out_mid_z) && (out_mid_z <= out_zmax) &&
                  (out_longest_axis != 2'd3))
    else $error("midpoint outside bounds or bad axis code");

endmodule

bind aabb_transform_and_metrics_core aabb_chk u_aabb_chk (.*);

/* test/tb_aabb_transform_and_metrics_core.sv */
`timescale 1ns / 1ps
// Testbench for aabb_transform_and_metrics_core: drives boxes and transform
// settings, predicts every result word in place and checks it field by field.
// Depends on aabb_pkg and the core's RTL.
module tb_aabb_transform_and_metrics_core;

  typedef logic signed [aabb_pkg::COORD_W-1:0] coord_t;
  typedef logic signed [aabb_pkg::COEF_W-1:0] coef_t;

  // One box word as it stands on the input ports
  typedef struct packed {
    coord_t xmin, xmax, ymin, ymax, zmin, zmax;
  } box_word_t;

  // One result word: transformed bounds and metrics
  typedef struct packed {
    coord_t xmin, xmax, ymin, ymax, zmin, zmax;
    coord_t mid_x, mid_y, mid_z;
    logic [aabb_pkg::AREA_W-1:0] area;
    logic [1:0] longest;
  } box_metrics_t;

  localparam int PIPE_DEPTH = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int BOXES_PER_SETTING = 120;
  localparam int SHOWN_MISMATCHES = 10;
  localparam coord_t C_MAX = {1'b0, {(aabb_pkg::COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(aabb_pkg::COORD_W-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) << (aabb_pkg::COORD_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam coef_t COEF_POS_MAX = 16'h7FFF;
  localparam coef_t COEF_NEG_MAX = 16'h8000;
  localparam coef_t COEF_NEG_HALF = 16'hF800;
  // Indexes past the register list; writes there must be dropped
  localparam logic [aabb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [aabb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_xmin, in_xmax, in_ymin, in_ymax, in_zmin, in_zmax;
  logic out_valid;
  coord_t out_xmin, out_xmax, out_ymin, out_ymax, out_zmin, out_zmax;
  coord_t out_mid_x, out_mid_y, out_mid_z;
  logic [aabb_pkg::AREA_W-1:0] out_area;
  logic [1:0] out_longest_axis;
  logic cfg_we;
  logic [aabb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [aabb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the transform registers
  logic [aabb_pkg::ROW_W-1:0] xform_rows [3];
  coord_t xlate [3];

  box_metrics_t expected_metrics [$];
  int boxes_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;

  aabb_transform_and_metrics_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_xmin(in_xmin), .in_xmax(in_xmax), .in_ymin(in_ymin),
    .in_ymax(in_ymax), .in_zmin(in_zmin), .in_zmax(in_zmax),
    .out_valid(out_valid),
    .out_xmin(out_xmin), .out_xmax(out_xmax), .out_ymin(out_ymin),
    .out_ymax(out_ymax), .out_zmin(out_zmin), .out_zmax(out_zmax),
    .out_mid_x(out_mid_x), .out_mid_y(out_mid_y), .out_mid_z(out_mid_z),
    .out_area(out_area), .out_longest_axis(out_longest_axis),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Transform all eight corners, take bounds, then midpoint, area, longest axis
  function automatic box_metrics_t transform_box(input box_word_t b);
    longint lo_v [3];
    longint hi_v [3];
    longint pt [3];
    longint bmin [3];
    longint bmax [3];
    longint ext [3];
    longint acc;
    longint v;
    longint mid [3];
    longint unsigned area_acc;
    coef_t c;
    box_metrics_t r;
    lo_v[0] = longint'($signed(b.xmin));
    hi_v[0] = longint'($signed(b.xmax));
    lo_v[1] = longint'($signed(b.ymin));
    hi_v[1] = longint'($signed(b.ymax));
    lo_v[2] = longint'($signed(b.zmin));
    hi_v[2] = longint'($signed(b.zmax));
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 3; j++) pt[j] = k[j] ? hi_v[j] : lo_v[j];
      for (int a = 0; a < 3; a++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          c = xform_rows[a][aabb_pkg::COEF_W*j +: aabb_pkg::COEF_W];
          acc += longint'(c) * pt[j];
        end
        // floor on the fraction drop, then translate and clamp
        v = (acc >>> aabb_pkg::FRAC_W) + longint'(xlate[a]);
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        if (k == 0 || v < bmin[a]) bmin[a] = v;
        if (k == 0 || v > bmax[a]) bmax[a] = v;
      end
    end
    for (int a = 0; a < 3; a++) begin
      ext[a] = bmax[a] - bmin[a];
      mid[a] = (bmin[a] + bmax[a]) >>> 1;
    end
    area_acc = ext[0] * ext[2] + ext[1] * ext[2] + ext[1] * ext[0];
    area_acc = area_acc * 2;
    if (area_acc > aabb_pkg::AREA_MAX) area_acc = 64'(aabb_pkg::AREA_MAX);
    r.xmin = bmin[0][aabb_pkg::COORD_W-1:0];
    r.xmax = bmax[0][aabb_pkg::COORD_W-1:0];
    r.ymin = bmin[1][aabb_pkg::COORD_W-1:0];
    r.ymax = bmax[1][aabb_pkg::COORD_W-1:0];
    r.zmin = bmin[2][aabb_pkg::COORD_W-1:0];
    r.zmax = bmax[2][aabb_pkg::COORD_W-1:0];
    r.mid_x = mid[0][aabb_pkg::COORD_W-1:0];
    r.mid_y = mid[1][aabb_pkg::COORD_W-1:0];
    r.mid_z = mid[2][aabb_pkg::COORD_W-1:0];
    r.area = area_acc[aabb_pkg::AREA_W-1:0];
    // ties go to the later axis: y over x, z over both
    if (ext[0] > ext[1] && ext[0] > ext[2]) r.longest = aabb_pkg::AXIS_X;
    else if (ext[1] > ext[2]) r.longest = aabb_pkg::AXIS_Y;
    else r.longest = aabb_pkg::AXIS_Z;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v) begin
      if (mismatch_count < SHOWN_MISMATCHES)
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Result checker and acceptance tracking, both at the rising edge
  always @(posedge clk) begin : track_words
    box_metrics_t got;
    box_metrics_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_xmin, out_xmax, out_ymin, out_ymax, out_zmin, out_zmax,
               out_mid_x, out_mid_y, out_mid_z, out_area, out_longest_axis};
        if (expected_metrics.size() == 0) begin
          if (mismatch_count < SHOWN_MISMATCHES)
            $display("[%0t] result word with nothing outstanding", $time);
          mismatch_count++;
        end else begin
          want = expected_metrics.pop_front();
          compare_field("xmin", 64'(want.xmin), 64'(got.xmin));
          compare_field("xmax", 64'(want.xmax), 64'(got.xmax));
          compare_field("ymin", 64'(want.ymin), 64'(got.ymin));
          compare_field("ymax", 64'(want.ymax), 64'(got.ymax));
          compare_field("zmin", 64'(want.zmin), 64'(got.zmin));
          compare_field("zmax", 64'(want.zmax), 64'(got.zmax));
          compare_field("mid_x", 64'(want.mid_x), 64'(got.mid_x));
          compare_field("mid_y", 64'(want.mid_y), 64'(got.mid_y));
          compare_field("mid_z", 64'(want.mid_z), 64'(got.mid_z));
          compare_field("area", 64'(want.area), 64'(got.area));
          compare_field("longest_axis", 64'(want.longest), 64'(got.longest));
        end
        results_seen++;
      end
      if (start && !busy) begin
        expected_metrics.push_back(transform_box(
          {in_xmin, in_xmax, in_ymin, in_ymax, in_zmin, in_zmax}));
        boxes_accepted++;
      end
    end
  end

  // Drive one box word, with random idle cycles ahead of it
  task automatic send_box(input coord_t xl, input coord_t xh, input coord_t yl,
                          input coord_t yh, input coord_t zl, input coord_t zh);
    int target;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_xmin <= xl;
    in_xmax <= xh;
    in_ymin <= yl;
    in_ymax <= yh;
    in_zmin <= zl;
    in_zmax <= zh;
    target = boxes_accepted + 1;
    wait (boxes_accepted == target);
  endtask

  // Stop sending and wait until every outstanding word has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    wait (results_seen == boxes_accepted);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic reset_transform_model();
    xform_rows[0] = aabb_pkg::ROW_X_RST;
    xform_rows[1] = aabb_pkg::ROW_Y_RST;
    xform_rows[2] = aabb_pkg::ROW_Z_RST;
    for (int a = 0; a < 3; a++) xlate[a] = '0;
  endtask

  // One register write; only called with the core idle
  task automatic write_xform_reg(input logic [aabb_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [aabb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      aabb_pkg::REG_ROW_X: xform_rows[0] = data[aabb_pkg::ROW_W-1:0];
      aabb_pkg::REG_ROW_Y: xform_rows[1] = data[aabb_pkg::ROW_W-1:0];
      aabb_pkg::REG_ROW_Z: xform_rows[2] = data[aabb_pkg::ROW_W-1:0];
      aabb_pkg::REG_OFF_X: xlate[0] = data[aabb_pkg::COORD_W-1:0];
      aabb_pkg::REG_OFF_Y: xlate[1] = data[aabb_pkg::COORD_W-1:0];
      aabb_pkg::REG_OFF_Z: xlate[2] = data[aabb_pkg::COORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(8191)) - coord_t'(4096);
      2: return coord_t'($urandom_range(131071)) - coord_t'(65536);
      default: begin
        case ($urandom_range(3))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(5))
      0, 1: return coef_t'($urandom);
      2: return coef_t'($urandom_range(8192)) - coef_t'(4096);
      3: return $urandom_range(1) ? COEF_POS_MAX : COEF_NEG_MAX;
      4: return '0;
      default: return $urandom_range(1) ? aabb_pkg::COEF_ONE : -aabb_pkg::COEF_ONE;
    endcase
  endfunction

  function automatic coord_t rand_offset();
    case ($urandom_range(4))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(8191)) - coord_t'(4096);
      2: return C_MAX;
      3: return C_MIN;
      default: return '0;
    endcase
  endfunction

  // Identity after reset: output bounds equal the input box, with swapped bounds put in order
  task automatic test_identity_boxes();
    send_box('0, '0, '0, '0, '0, '0);
    send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    // swapped bounds come out ordered
    send_box(C_MAX, C_MIN, 24'sd500, -24'sd500, C_MAX, C_MIN);
    // longest axis: x strict, x=y tie, x=z tie, y over z
    send_box(24'sd0, 24'sd1000, 24'sd0, 24'sd10, 24'sd0, 24'sd10);
    send_box(24'sd0, 24'sd1000, 24'sd0, 24'sd1000, 24'sd0, 24'sd10);
    send_box(24'sd0, 24'sd1000, 24'sd0, 24'sd10, 24'sd0, 24'sd1000);
    send_box(24'sd0, 24'sd5, -24'sd300, 24'sd300, 24'sd0, 24'sd100);
    // odd negative half-sum rounds down
    send_box(-24'sd3, 24'sd0, -24'sd7, 24'sd2, C_MIN, C_MAX - 24'sd1);
  endtask

  // Each register, extreme settings, saturation, floor rounding, dropped writes
  task automatic test_register_writes();
    drain_results();
    write_xform_reg(aabb_pkg::REG_ROW_X, {3{COEF_POS_MAX}});
    write_xform_reg(aabb_pkg::REG_ROW_Y, {3{COEF_POS_MAX}});
    write_xform_reg(aabb_pkg::REG_ROW_Z, {3{COEF_POS_MAX}});
    write_xform_reg(aabb_pkg::REG_OFF_X, {24'hFFFFFF, C_MAX});
    write_xform_reg(aabb_pkg::REG_OFF_Y, {24'hA5A5A5, C_MIN});
    write_xform_reg(aabb_pkg::REG_OFF_Z, {24'h000000, 24'sd12345});
    send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_box(-24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1);
    drain_results();
    write_xform_reg(aabb_pkg::REG_ROW_X, {3{COEF_NEG_MAX}});
    write_xform_reg(aabb_pkg::REG_ROW_Y, {COEF_NEG_MAX, 16'h0000, COEF_POS_MAX});
    write_xform_reg(aabb_pkg::REG_ROW_Z, {16'h0000, COEF_NEG_MAX, 16'h0000});
    write_xform_reg(aabb_pkg::REG_OFF_X, {24'h5A5A5A, C_MIN});
    send_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    send_box(C_MAX, C_MAX, C_MIN, C_MIN, '0, '0);
    drain_results();
    // minus one half on each diagonal: exercises floor on the fraction drop
    write_xform_reg(aabb_pkg::REG_ROW_X, {32'h0, COEF_NEG_HALF});
    write_xform_reg(aabb_pkg::REG_ROW_Y, {16'h0, COEF_NEG_HALF, 16'h0});
    write_xform_reg(aabb_pkg::REG_ROW_Z, {COEF_NEG_HALF, 32'h0});
    write_xform_reg(aabb_pkg::REG_OFF_X, '0);
    write_xform_reg(aabb_pkg::REG_OFF_Y, '0);
    write_xform_reg(aabb_pkg::REG_OFF_Z, {24'hFFFFFF, 24'h000000});
    send_box(-24'sd3, 24'sd5, -24'sd1, 24'sd1, 24'sd7, -24'sd9);
    send_box(24'sd1, 24'sd3, -24'sd5, -24'sd3, C_MIN, C_MAX);
    drain_results();
    // writes past the register list leave the transform as it is
    write_xform_reg(REG_SPARE_A, '1);
    write_xform_reg(REG_SPARE_B, {3{16'h1234}});
    send_box(-24'sd3, 24'sd5, -24'sd1, 24'sd1, 24'sd7, -24'sd9);
    drain_results();
    // mixed rotation-like transform with translation
    write_xform_reg(aabb_pkg::REG_ROW_X, {16'h0000, 16'hF000, 16'h0B50});
    write_xform_reg(aabb_pkg::REG_ROW_Y, {16'h0800, 16'h0B50, 16'h0000});
    write_xform_reg(aabb_pkg::REG_ROW_Z, {16'h1000, 16'h0000, 16'h04B0});
    write_xform_reg(aabb_pkg::REG_OFF_X, 48'sd256);
    write_xform_reg(aabb_pkg::REG_OFF_Y, -48'sd1024);
    write_xform_reg(aabb_pkg::REG_OFF_Z, 48'sd77);
    send_box(-24'sd2560, 24'sd2560, -24'sd100, 24'sd300, 24'sd0, 24'sd4096);
    send_box(24'sd100, -24'sd100, 24'sd4000, 24'sd4001, -24'sd70000, 24'sd70000);
  endtask

  // New transform: identity, or random rows and offsets with junk upper bits
  task automatic load_transform(input bit identity);
    drain_results();
    if (identity) begin
      write_xform_reg(aabb_pkg::REG_ROW_X, aabb_pkg::ROW_X_RST);
      write_xform_reg(aabb_pkg::REG_ROW_Y, aabb_pkg::ROW_Y_RST);
      write_xform_reg(aabb_pkg::REG_ROW_Z, aabb_pkg::ROW_Z_RST);
      write_xform_reg(aabb_pkg::REG_OFF_X, '0);
      write_xform_reg(aabb_pkg::REG_OFF_Y, '0);
      write_xform_reg(aabb_pkg::REG_OFF_Z, '0);
    end else begin
      write_xform_reg(aabb_pkg::REG_ROW_X, {rand_coef(), rand_coef(), rand_coef()});
      write_xform_reg(aabb_pkg::REG_ROW_Y, {rand_coef(), rand_coef(), rand_coef()});
      write_xform_reg(aabb_pkg::REG_ROW_Z, {rand_coef(), rand_coef(), rand_coef()});
      write_xform_reg(aabb_pkg::REG_OFF_X, {24'($urandom), rand_offset()});
      write_xform_reg(aabb_pkg::REG_OFF_Y, {24'($urandom), rand_offset()});
      write_xform_reg(aabb_pkg::REG_OFF_Z, {24'($urandom), rand_offset()});
      if ($urandom_range(3) == 0)
        write_xform_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                        48'({$urandom, $urandom}));
    end
  endtask

  // Random boxes under three idle patterns, several transforms in each
  task automatic test_random_boxes();
    int idle_pattern [3];
    coord_t lo_b [3];
    coord_t hi_b [3];
    coord_t tmp;
    idle_pattern = '{32, 66, 0};
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_pattern[ph];
      for (int s = 0; s < 4; s++) begin
        load_transform(s == 0 && ph == 0);
        for (int n = 0; n < BOXES_PER_SETTING; n++) begin
          for (int a = 0; a < 3; a++) begin
            lo_b[a] = rand_coord();
            hi_b[a] = rand_coord();
            // mostly well-ordered boxes, some left swapped
            if ($urandom_range(9) < 7 && lo_b[a] > hi_b[a]) begin
              tmp = lo_b[a];
              lo_b[a] = hi_b[a];
              hi_b[a] = tmp;
            end
          end
          send_box(lo_b[0], hi_b[0], lo_b[1], hi_b[1], lo_b[2], hi_b[2]);
          // now and then hold off until the pipeline is empty
          if ($urandom_range(59) == 0) drain_results();
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_xmin = '0;
    in_xmax = '0;
    in_ymin = '0;
    in_ymax = '0;
    in_zmin = '0;
    in_zmax = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_transform_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 32;
    test_identity_boxes();
    test_register_writes();
    test_random_boxes();
    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
